### sv/sre_pkg.sv
`timescale 1ns / 1ps
package sre_pkg;

    // Sample format and fixed field widths
    localparam int SAMPLE_BITS      = 24;
    localparam int DEF_MAX_FRAMES   = 16384;
    localparam int DEF_MAX_CHANNELS = 2;
    localparam int FRAME_W          = 15;
    localparam int CHAN_W           = 2;
    localparam int WALK_W           = 17;
    localparam int TARGET_W         = 23;
    localparam int PROD_W           = 47;
    localparam int SUM_W            = 38;
    localparam int MEAN_W           = 25;
    localparam int DIV_DW           = 48;
    localparam int DIV_VW           = 24;
    localparam int CFG_W            = 15;

    // -96 dB below full scale at 24 bits, rounded up
    localparam logic [SAMPLE_BITS-1:0] QUIET_LIMIT = SAMPLE_BITS'(133);

    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Configuration register indexes
    localparam logic CFG_CHANNEL_COUNT = 1'b0;
    localparam logic CFG_FRAME_COUNT   = 1'b1;

    typedef enum logic [2:0] {
        MODE_WRITE    = 3'd0,
        MODE_READ     = 3'd1,
        MODE_SILENCE  = 3'd2,
        MODE_FADE_IN  = 3'd3,
        MODE_FADE_OUT = 3'd4,
        MODE_NORM     = 3'd5,
        MODE_DC       = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_QUIET = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        WALK_REGION = 2'd0,
        WALK_CHAN   = 2'd1,
        WALK_ALL    = 2'd2
    } t_walk;

    typedef enum logic [1:0] {
        WR_ACCESS = 2'd0,
        WR_ZERO   = 2'd1,
        WR_QUOT   = 2'd2,
        WR_DC     = 2'd3
    } t_wsel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_ACC_RD,
        S_CLR,
        S_F_RD,
        S_F_MUL,
        S_F_DSTART,
        S_F_DWAIT,
        S_F_WR,
        S_P_RD,
        S_P_CMP,
        S_P_CHK,
        S_DC_INIT,
        S_DC_SRD,
        S_DC_SUM,
        S_DC_DSTART,
        S_DC_DWAIT,
        S_DC_RD,
        S_DC_WR,
        S_DC_NEXT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    acc;
        logic    rd;
        logic    wr;
        t_wsel   wsel;
        logic    walk_init;
        t_walk   walk_sel;
        logic    walk_next;
        logic    peak_clr;
        logic    peak_upd;
        logic    sum_clr;
        logic    sum_upd;
        logic    mul;
        logic    div_start;
        logic    div_sum;
        logic    mean_ld;
        logic    ch_clr;
        logic    ch_next;
        logic    res_ld;
        logic    res_read;
        t_status res_code;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       oob;
        logic       empty;
        logic       quiet;
        logic       last;
        logic       div_done;
        logic       ch_last;
        logic       out_free;
    } t_dp_stat;

endpackage

### sv/sre_ram.sv
`timescale 1ns / 1ps
module sre_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/sre_div.sv
`timescale 1ns / 1ps
module sre_div #(
    parameter int DW = 48,
    parameter int VW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quotient,
    output logic          o_done
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_div;
    logic [DW-1:0]    r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [VW:0]      trial;
    logic             qbit;
    logic [VW:0]      diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        diff  = trial - {1'b0, r_div};
        qbit  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[VW-1:0] : trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], qbit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = !r_busy;

endmodule

### sv/sre_datapath.sv
`timescale 1ns / 1ps
module sre_datapath
    import sre_pkg::*;
#(
    parameter int MAX_FRAMES   = DEF_MAX_FRAMES,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat,
    input  logic [2:0]                    i_mode,
    input  logic [13:0]                   i_frame,
    input  logic                          i_channel,
    input  logic signed [SAMPLE_BITS-1:0] i_write_value,
    input  logic [FRAME_W-1:0]            i_region_start,
    input  logic [FRAME_W-1:0]            i_region_end,
    input  logic [TARGET_W-1:0]           i_target_amplitude,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_read_value,
    output logic [1:0]                    o_status
);

    localparam int DEPTH = MAX_FRAMES * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);

    // Latched command word
    logic [2:0]             r_mode;
    logic [13:0]            r_frame;
    logic                   r_channel;
    logic [SAMPLE_BITS-1:0] r_wval;
    logic [FRAME_W-1:0]     r_from;
    logic [FRAME_W-1:0]     r_to;
    logic [TARGET_W-1:0]    r_target;

    // Configuration
    logic [CHAN_W-1:0]      r_cfg_chan;
    logic [FRAME_W-1:0]     r_cfg_frames;

    // Walk state
    logic [WALK_W-1:0]      r_addr;
    logic [WALK_W-1:0]      r_end;
    logic [CHAN_W-1:0]      r_step;
    logic [CHAN_W-1:0]      r_j;
    logic [FRAME_W-1:0]     r_k;
    logic [CHAN_W-1:0]      r_ch;

    // Arithmetic state
    logic [SAMPLE_BITS-1:0] r_peak;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [MEAN_W-1:0] r_mean;
    logic [PROD_W-1:0]      r_prod;
    logic                   r_neg;

    // Result word
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_read_value;
    logic [1:0]             r_status;

    logic [CHAN_W-1:0]      nc;
    logic [FRAME_W-1:0]     nf;
    logic [FRAME_W-1:0]     to_c;
    logic [FRAME_W-1:0]     n;
    logic [FRAME_W-1:0]     gain;
    logic [WALK_W-1:0]      acc_addr;
    logic [WALK_W-1:0]      region_lo;
    logic [WALK_W-1:0]      region_hi;
    logic [WALK_W-1:0]      all_hi;
    logic [WALK_W-1:0]      sel_addr;
    logic [SAMPLE_BITS-1:0] rdata;
    logic [SAMPLE_BITS-1:0] abs_s;
    logic [TARGET_W-1:0]    mval;
    logic [SUM_W-1:0]       abs_sum;
    logic [DIV_DW-1:0]      dividend;
    logic [DIV_VW-1:0]      divisor;
    logic [DIV_DW-1:0]      quo;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] quot_sat;
    logic signed [SAMPLE_BITS+1:0] dc_diff;
    logic [SAMPLE_BITS-1:0] dc_sat;
    logic [SAMPLE_BITS-1:0] wdata;

    // Clamp the configuration to what the store holds
    always_comb begin
        if (r_cfg_chan == '0) begin
            nc = CHAN_W'(1);
        end else if (int'(r_cfg_chan) > MAX_CHANNELS) begin
            nc = CHAN_W'(MAX_CHANNELS);
        end else begin
            nc = r_cfg_chan;
        end
        if (int'(r_cfg_frames) > MAX_FRAMES) begin
            nf = FRAME_W'(MAX_FRAMES);
        end else begin
            nf = r_cfg_frames;
        end
    end

    assign to_c      = (r_to > nf) ? nf : r_to;
    assign n         = to_c - r_from;
    assign gain      = (r_mode == MODE_FADE_IN) ? r_k : (n - r_k);
    assign acc_addr  = WALK_W'(r_frame) * WALK_W'(nc) + WALK_W'(r_channel);
    assign region_lo = WALK_W'(r_from) * WALK_W'(nc);
    assign region_hi = WALK_W'(to_c) * WALK_W'(nc);
    assign all_hi    = WALK_W'(nf) * WALK_W'(nc);
    assign sel_addr  = i_cmd.acc ? acc_addr : r_addr;

    // Status toward the controller
    always_comb begin
        o_stat.mode     = r_mode;
        o_stat.oob      = ({1'b0, r_frame} >= nf) || ({1'b0, r_channel} >= nc);
        o_stat.empty    = (r_from >= to_c);
        o_stat.quiet    = (r_peak < QUIET_LIMIT);
        o_stat.last     = ((r_addr + WALK_W'(r_step)) >= r_end);
        o_stat.div_done = div_done;
        o_stat.ch_last  = (r_ch == (nc - 1'b1));
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // Capture the command word and configuration writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_frame   <= i_frame;
            r_channel <= i_channel;
            r_wval    <= i_write_value;
            r_from    <= i_region_start;
            r_to      <= i_region_end;
            r_target  <= i_target_amplitude;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_chan   <= CHAN_W'(1);
            r_cfg_frames <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_cfg_chan   <= i_cfg_data[CHAN_W-1:0];
                CFG_FRAME_COUNT:   r_cfg_frames <= i_cfg_data[FRAME_W-1:0];
                default:           r_cfg_frames <= r_cfg_frames;
            endcase
        end
    end

    // Walk over the store: set a range, then advance one entry or one frame stride
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_j <= '0;
            r_k <= '0;
            unique case (i_cmd.walk_sel)
                WALK_REGION: begin
                    r_addr <= region_lo;
                    r_end  <= region_hi;
                    r_step <= CHAN_W'(1);
                end
                WALK_CHAN: begin
                    r_addr <= region_lo + WALK_W'(r_ch);
                    r_end  <= region_hi;
                    r_step <= nc;
                end
                WALK_ALL: begin
                    r_addr <= '0;
                    r_end  <= all_hi;
                    r_step <= CHAN_W'(1);
                end
                default: begin
                    r_addr <= '0;
                    r_end  <= '0;
                    r_step <= CHAN_W'(1);
                end
            endcase
        end else if (i_cmd.walk_next) begin
            r_addr <= r_addr + WALK_W'(r_step);
            if (r_j == (nc - 1'b1)) begin
                r_j <= '0;
                r_k <= r_k + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ch_clr) begin
            r_ch <= '0;
        end else if (i_cmd.ch_next) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    sre_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (AW'(sel_addr)),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (AW'(sel_addr)),
        .o_rdata (rdata)
    );

    assign abs_s   = rdata[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - rdata) : rdata;
    assign mval    = (r_mode == MODE_NORM) ? r_target : TARGET_W'(gain);
    assign abs_sum = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    // Peak and per-channel sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_sum  <= '0;
        end else begin
            if (i_cmd.peak_clr) begin
                r_peak <= '0;
            end else if (i_cmd.peak_upd && (abs_s > r_peak)) begin
                r_peak <= abs_s;
            end
            if (i_cmd.sum_clr) begin
                r_sum <= '0;
            end else if (i_cmd.sum_upd) begin
                r_sum <= r_sum + SUM_W'(signed'(rdata));
            end
        end
    end

    // Magnitude product, sign kept aside
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(abs_s) * PROD_W'(mval);
            r_neg  <= rdata[SAMPLE_BITS-1];
        end
    end

    assign dividend = i_cmd.div_sum ? DIV_DW'(abs_sum) : DIV_DW'(r_prod);
    assign divisor  = (!i_cmd.div_sum && (r_mode == MODE_NORM)) ? DIV_VW'(r_peak)
                                                                : DIV_VW'(n);

    sre_div #(
        .DW (DIV_DW),
        .VW (DIV_VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    // Apply sign and saturate the scaled sample
    always_comb begin
        if (r_neg) begin
            if (quo > DIV_DW'(SMIN)) begin
                quot_sat = SMIN;
            end else begin
                quot_sat = SAMPLE_BITS'(0) - quo[SAMPLE_BITS-1:0];
            end
        end else begin
            if (quo > DIV_DW'(SMAX)) begin
                quot_sat = SMAX;
            end else begin
                quot_sat = quo[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_ld) begin
            if (r_sum[SUM_W-1]) begin
                r_mean <= MEAN_W'(0) - MEAN_W'(quo);
            end else begin
                r_mean <= MEAN_W'(quo);
            end
        end
    end

    // Subtract the mean and saturate
    always_comb begin
        dc_diff = {{2{rdata[SAMPLE_BITS-1]}}, rdata} - {r_mean[MEAN_W-1], r_mean};
        if (dc_diff > signed'({2'b00, SMAX})) begin
            dc_sat = SMAX;
        end else if (dc_diff < signed'({2'b11, SMIN})) begin
            dc_sat = SMIN;
        end else begin
            dc_sat = dc_diff[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        unique case (i_cmd.wsel)
            WR_ACCESS: wdata = r_wval;
            WR_ZERO:   wdata = '0;
            WR_QUOT:   wdata = quot_sat;
            WR_DC:     wdata = dc_sat;
            default:   wdata = '0;
        endcase
    end

    // Result word, held until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_read_value <= i_cmd.res_read ? rdata : '0;
            r_status     <= i_cmd.res_code;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;

endmodule

### sv/sre_ctrl.sv
`timescale 1ns / 1ps
module sre_ctrl
    import sre_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_ready;

    assign in_ready   = (r_state == S_IDLE) && i_stat.out_free;
    assign o_in_ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && in_ready) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.mode)
                    MODE_WRITE: n_state = S_IDLE;
                    MODE_READ:  n_state = i_stat.oob ? S_IDLE : S_ACC_RD;
                    MODE_SILENCE: n_state = i_stat.empty ? S_IDLE : S_CLR;
                    MODE_FADE_IN, MODE_FADE_OUT: n_state = i_stat.empty ? S_IDLE : S_F_RD;
                    MODE_NORM:  n_state = i_stat.empty ? S_IDLE : S_P_RD;
                    MODE_DC:    n_state = i_stat.empty ? S_IDLE : S_DC_INIT;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_ACC_RD:    n_state = S_IDLE;
            S_CLR:       n_state = i_stat.last ? S_IDLE : S_CLR;
            S_F_RD:      n_state = S_F_MUL;
            S_F_MUL:     n_state = S_F_DSTART;
            S_F_DSTART:  n_state = S_F_DWAIT;
            S_F_DWAIT:   n_state = i_stat.div_done ? S_F_WR : S_F_DWAIT;
            S_F_WR:      n_state = i_stat.last ? S_IDLE : S_F_RD;
            S_P_RD:      n_state = S_P_CMP;
            S_P_CMP:     n_state = i_stat.last ? S_P_CHK : S_P_RD;
            S_P_CHK:     n_state = i_stat.quiet ? S_IDLE : S_F_RD;
            S_DC_INIT:   n_state = S_DC_SRD;
            S_DC_SRD:    n_state = S_DC_SUM;
            S_DC_SUM:    n_state = i_stat.last ? S_DC_DSTART : S_DC_SRD;
            S_DC_DSTART: n_state = S_DC_DWAIT;
            S_DC_DWAIT:  n_state = i_stat.div_done ? S_DC_RD : S_DC_DWAIT;
            S_DC_RD:     n_state = S_DC_WR;
            S_DC_WR: begin
                if (i_stat.last) begin
                    n_state = i_stat.ch_last ? S_IDLE : S_DC_NEXT;
                end else begin
                    n_state = S_DC_RD;
                end
            end
            S_DC_NEXT:   n_state = S_DC_INIT;
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid && in_ready;
            end
            S_DECODE: begin
                unique case (i_stat.mode)
                    MODE_WRITE: begin
                        o_cmd.res_ld = 1'b1;
                        if (i_stat.oob) begin
                            o_cmd.res_code = ST_RANGE;
                        end else begin
                            o_cmd.acc      = 1'b1;
                            o_cmd.wr       = 1'b1;
                            o_cmd.wsel     = WR_ACCESS;
                            o_cmd.res_code = ST_DONE;
                        end
                    end
                    MODE_READ: begin
                        if (i_stat.oob) begin
                            o_cmd.res_ld   = 1'b1;
                            o_cmd.res_code = ST_RANGE;
                        end else begin
                            o_cmd.acc = 1'b1;
                            o_cmd.rd  = 1'b1;
                        end
                    end
                    MODE_SILENCE, MODE_FADE_IN, MODE_FADE_OUT, MODE_NORM, MODE_DC: begin
                        if (i_stat.empty) begin
                            o_cmd.res_ld   = 1'b1;
                            o_cmd.res_code = ST_EMPTY;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            o_cmd.walk_sel  = WALK_REGION;
                            o_cmd.peak_clr  = 1'b1;
                            o_cmd.ch_clr    = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.res_ld   = 1'b1;
                        o_cmd.res_code = ST_RANGE;
                    end
                endcase
            end
            S_ACC_RD: begin
                o_cmd.res_ld   = 1'b1;
                o_cmd.res_read = 1'b1;
                o_cmd.res_code = ST_DONE;
            end
            S_CLR: begin
                o_cmd.wr        = 1'b1;
                o_cmd.wsel      = WR_ZERO;
                o_cmd.walk_next = 1'b1;
                o_cmd.res_ld    = i_stat.last;
                o_cmd.res_code  = ST_DONE;
            end
            S_F_RD: begin
                o_cmd.rd = 1'b1;
            end
            S_F_MUL: begin
                o_cmd.mul = 1'b1;
            end
            S_F_DSTART: begin
                o_cmd.div_start = 1'b1;
            end
            S_F_DWAIT: begin
                o_cmd.wsel = WR_QUOT;
            end
            S_F_WR: begin
                o_cmd.wr        = 1'b1;
                o_cmd.wsel      = WR_QUOT;
                o_cmd.walk_next = 1'b1;
                o_cmd.res_ld    = i_stat.last;
                o_cmd.res_code  = ST_DONE;
            end
            S_P_RD: begin
                o_cmd.rd = 1'b1;
            end
            S_P_CMP: begin
                o_cmd.peak_upd  = 1'b1;
                o_cmd.walk_next = 1'b1;
            end
            S_P_CHK: begin
                if (i_stat.quiet) begin
                    o_cmd.res_ld   = 1'b1;
                    o_cmd.res_code = ST_QUIET;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    o_cmd.walk_sel  = WALK_ALL;
                end
            end
            S_DC_INIT: begin
                o_cmd.walk_init = 1'b1;
                o_cmd.walk_sel  = WALK_CHAN;
                o_cmd.sum_clr   = 1'b1;
            end
            S_DC_SRD: begin
                o_cmd.rd = 1'b1;
            end
            S_DC_SUM: begin
                o_cmd.sum_upd   = 1'b1;
                o_cmd.walk_next = 1'b1;
            end
            S_DC_DSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sum   = 1'b1;
            end
            S_DC_DWAIT: begin
                o_cmd.div_sum = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.mean_ld   = 1'b1;
                    o_cmd.walk_init = 1'b1;
                    o_cmd.walk_sel  = WALK_CHAN;
                end
            end
            S_DC_RD: begin
                o_cmd.rd = 1'b1;
            end
            S_DC_WR: begin
                o_cmd.wr        = 1'b1;
                o_cmd.wsel      = WR_DC;
                o_cmd.walk_next = 1'b1;
                o_cmd.res_ld    = i_stat.last && i_stat.ch_last;
                o_cmd.res_code  = ST_DONE;
            end
            S_DC_NEXT: begin
                o_cmd.ch_next = 1'b1;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

endmodule

### sv/sample_region_edit_engine.sv
`timescale 1ns / 1ps
// Write completes in the decode state; read adds a store read state; silence zeroes each
// region sample. Fade reads, multiplies, divides and writes back each sample; normalize
// first finds the region peak, then scales every sample of the whole buffer in use; DC
// removal sums each channel's region samples, divides by the frame count and subtracts
// the mean from them. 48-step one-bit-per-cycle divider; one store address. One command at a time.
// Reset (synchronous, active low) clears control, config and result; store is not cleared.
module sample_region_edit_engine
    import sre_pkg::*;
#(
    parameter int MAX_FRAMES   = DEF_MAX_FRAMES,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_mode,
    input  logic [13:0]                   i_frame,
    input  logic                          i_channel,
    input  logic signed [SAMPLE_BITS-1:0] i_write_value,
    input  logic [FRAME_W-1:0]            i_region_start,
    input  logic [FRAME_W-1:0]            i_region_end,
    input  logic [TARGET_W-1:0]           i_target_amplitude,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_read_value,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    sre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sre_datapath #(
        .MAX_FRAMES   (MAX_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_mode             (i_mode),
        .i_frame            (i_frame),
        .i_channel          (i_channel),
        .i_write_value      (i_write_value),
        .i_region_start     (i_region_start),
        .i_region_end       (i_region_end),
        .i_target_amplitude (i_target_amplitude),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_read_value       (o_read_value),
        .o_status           (o_status)
    );

endmodule
